// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the quantizer RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// check that a condition implies a consequence in the same cycle
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
// Types, constants and scale tables of the scale pitch quantizer.
// No dependencies.
package spq_pkg;

  typedef enum logic [1:0] {
    CMD_SNAP    = 2'd0,
    CMD_EDIT    = 2'd1,
    CMD_REBUILD = 2'd2
  } cmd_e;

  localparam int unsigned ClassCount = 12;
  localparam int unsigned SearchMax  = 6;

  localparam logic [11:0] FullMask   = 12'hFFF;
  localparam logic [3:0]  KindChrom  = 4'd0;
  localparam logic [3:0]  KindCustom = 4'd9;

  localparam logic        IdxScaleKind = 1'b0;
  localparam logic        IdxTonic     = 1'b1;

  // n / 12 as (n * 171) >> 11, exact for n up to 128
  localparam logic [7:0]  RecipMul   = 8'd171;
  localparam int unsigned RecipShift = 11;

  function automatic logic [11:0] scale_set(input logic [3:0] kind);
    logic [11:0] set;
    case (kind)
      4'd0:    set = 12'hFFF;
      4'd1:    set = 12'hAB5;
      4'd2:    set = 12'h5AD;
      4'd3:    set = 12'h9AD;
      4'd4:    set = 12'h295;
      4'd5:    set = 12'h4A9;
      4'd6:    set = 12'h4E9;
      4'd7:    set = 12'h6AD;
      4'd8:    set = 12'h6B5;
      4'd9:    set = 12'hFFF;
      default: set = 12'hFFF;
    endcase
    return set;
  endfunction

endpackage

// ===== hdl/scale_pitch_quantizer.sv =====
// Scale pitch quantizer: snaps pitches to an allowed pitch-class mask and edits the mask.
// Depends on spq_pkg and assert_macros.svh.
//
// Usage:
//   Input words arrive on s_axis: tuser carries the command (0 snap, 1 edit one class,
//   2 rebuild the mask from the registers). Each input word gives one output word on
//   m_axis with the snapped note, the exact flag, the mask and the scale kind after
//   the word.
//   The register port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes scale kind (index 0)
//   and tonic class (index 1); write it only while the block is idle.
//   An accepted word is held in the input register and then shows on m_axis from the
//   result register behind it. Throughput: one word per cycle while m_axis_tready is
//   high, as the snap search and mask update between the two registers are combinational.
//   Stall: while m_axis_tready is low a full result register holds, the input register
//   still fills, and s_axis_tready drops only when both are full.
//   Reset: mask allows all twelve classes, kind and registers are zero, both
//   registers empty.
`include "assert_macros.svh"

module scale_pitch_quantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pitch_fixed[14:0], pitch_class[18:15], allow_flag[19]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // snapped_note[8:0], was_exact[9], mask_now[21:10],
                                     // kind_now[25:22]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i
);

  logic              in_valid_q;
  spq_pkg::cmd_e     in_cmd_q;
  logic [14:0]       in_pitch_q;
  logic [3:0]        in_cls_q;
  logic              in_allow_q;

  logic              out_valid_q;
  logic signed [8:0] out_note_q;
  logic              out_exact_q;
  logic [11:0]       out_mask_q;
  logic [3:0]        out_kind_q;

  logic [11:0]       mask_q, mask_d;
  logic [3:0]        kind_q, kind_d;
  logic [3:0]        scale_kind_q;
  logic [3:0]        tonic_q;

  logic              out_free;
  logic              adv;
  logic              in_fire;

  logic [15:0]       round_sum;
  logic [7:0]        nearest;
  logic              prefer_below;
  logic [15:0]       recip_prod;
  logic [4:0]        quot;
  logic [7:0]        rem_full;
  logic [3:0]        cls0;
  logic [23:0]       rot_wide;
  logic [11:0]       rot;
  logic              found;
  logic              go_below;
  logic [2:0]        step_dist;
  logic signed [8:0] note_base;
  logic signed [8:0] note_d;
  logic              exact_d;

  logic [3:0]        edit_cls;
  logic [11:0]       edit_bit;
  logic              edit_have;
  logic [11:0]       edit_mask;
  logic [3:0]        rb_kind;
  logic [3:0]        rb_tonic;
  logic [23:0]       rb_wide;
  logic [11:0]       rb_mask;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_kind_q <= spq_pkg::KindChrom;
      tonic_q      <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == spq_pkg::IdxScaleKind) begin
        scale_kind_q <= cfg_wdata_i;
      end else begin
        tonic_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_cmd_q   <= spq_pkg::cmd_e'(s_axis_tuser);
      in_pitch_q <= s_axis_tdata[14:0];
      in_cls_q   <= s_axis_tdata[18:15];
      in_allow_q <= s_axis_tdata[19];
    end
  end

  // rounding and class of the rounded note
  assign round_sum    = {1'b0, in_pitch_q} + 16'd128;
  assign nearest      = round_sum[15:8];
  assign prefer_below = {1'b0, in_pitch_q} <= {nearest, 8'd0};
  assign recip_prod   = nearest * spq_pkg::RecipMul;
  assign quot         = recip_prod[15:spq_pkg::RecipShift];
  assign rem_full     = nearest - ({quot, 3'b000} + {1'b0, quot, 2'b00});
  assign cls0         = rem_full[3:0];
  assign rot_wide     = {mask_q, mask_q} >> cls0;
  assign rot          = rot_wide[11:0];
  assign note_base    = signed'({1'b0, nearest});

  always_comb begin
    found     = 1'b0;
    go_below  = 1'b0;
    step_dist = '0;
    for (int d = 1; d <= spq_pkg::SearchMax; d++) begin
      if (!found) begin
        if (prefer_below && rot[spq_pkg::ClassCount - d]) begin
          found     = 1'b1;
          go_below  = 1'b1;
          step_dist = 3'(d);
        end else if (rot[d]) begin
          found     = 1'b1;
          go_below  = 1'b0;
          step_dist = 3'(d);
        end else if (rot[spq_pkg::ClassCount - d]) begin
          found     = 1'b1;
          go_below  = 1'b1;
          step_dist = 3'(d);
        end
      end
    end
  end

  // edit and rebuild
  assign edit_cls  = (in_cls_q >= 4'd12) ? in_cls_q - 4'd12 : in_cls_q;
  assign edit_bit  = 12'd1 << edit_cls;
  assign edit_have = mask_q[edit_cls];
  assign edit_mask = in_allow_q ? (mask_q | edit_bit) : (mask_q & ~edit_bit);
  assign rb_kind   = (scale_kind_q > spq_pkg::KindCustom) ? spq_pkg::KindChrom : scale_kind_q;
  assign rb_tonic  = (tonic_q >= 4'd12) ? tonic_q - 4'd12 : tonic_q;
  assign rb_wide   = {spq_pkg::scale_set(rb_kind), spq_pkg::scale_set(rb_kind)} << rb_tonic;
  assign rb_mask   = rb_wide[23:12];

  always_comb begin
    mask_d  = mask_q;
    kind_d  = kind_q;
    note_d  = '0;
    exact_d = 1'b0;
    case (in_cmd_q)
      spq_pkg::CMD_SNAP: begin
        if (rot[0]) begin
          exact_d = 1'b1;
          note_d  = note_base;
        end else if (found && go_below) begin
          note_d = note_base - signed'({6'd0, step_dist});
        end else if (found) begin
          note_d = note_base + signed'({6'd0, step_dist});
        end else begin
          note_d = note_base;
        end
      end
      spq_pkg::CMD_EDIT: begin
        if (edit_have != in_allow_q) begin
          kind_d = spq_pkg::KindCustom;
          mask_d = (edit_mask == '0) ? edit_bit : edit_mask;
        end
      end
      spq_pkg::CMD_REBUILD: begin
        mask_d = rb_mask;
        kind_d = rb_kind;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= spq_pkg::FullMask;
      kind_q      <= spq_pkg::KindChrom;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        mask_q      <= mask_d;
        kind_q      <= kind_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_note_q  <= note_d;
      out_exact_q <= exact_d;
      out_mask_q  <= mask_d;
      out_kind_q  <= kind_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_kind_q, out_mask_q, out_exact_q, out_note_q};

  `SPQ_ASSERT(a_mask_nonempty, mask_q != '0, "class mask became empty")
  `SPQ_ASSERT(a_kind_range, kind_q <= spq_pkg::KindCustom, "scale kind out of range")
  `SPQ_ASSERT_IMP(a_out_matches_state, out_valid_q,
    (out_mask_q == mask_q) && (out_kind_q == kind_q), "pending result disagrees with state")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for scale_pitch_quantizer: directed and random words on the
// stream ports, register writes between phases, every output word checked in order.
// Depends on spq_pkg and the quantizer RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] CmdNoop    = 2'd3;
  localparam int         HoldCycles = 80;
  localparam int         IdleLimit  = 1000;
  localparam int         RandomWords = 1730;

  localparam logic [11:0] ScaleTable [10] = '{
    12'hFFF, 12'hAB5, 12'h5AD, 12'h9AD, 12'h295,
    12'h4A9, 12'h4E9, 12'h6AD, 12'h6B5, 12'hFFF
  };

  typedef struct {
    logic signed [8:0] note;
    logic              exact;
    logic [11:0]       mask;
    logic [3:0]        kind;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // pitch_fixed[14:0], pitch_class[18:15], allow_flag[19]
  logic [1:0]  s_axis_tuser = '0;   // command[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // snapped_note[8:0], was_exact[9], mask_now[21:10],
                                    // kind_now[25:22]
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;

  result_t     due_results[$];
  logic [11:0] model_mask = spq_pkg::FullMask;
  logic [3:0]  model_kind = spq_pkg::KindChrom;
  logic [3:0]  reg_kind = '0;
  logic [3:0]  reg_tonic = '0;

  int  burst_left = 0;
  bit  gapless = 1'b0;
  int  hold_reqs = 0;
  int  holds_done = 0;
  int  hold_left = 0;
  int  ready_mode = 0;
  int  mode_left = 0;
  int  fail_count = 0;
  int  words_sent = 0;
  int  results_seen = 0;
  int  scale_writes = 0;
  int  word_count [4] = '{0, 0, 0, 0};

  scale_pitch_quantizer DUT (.*);

  always #4 clk_i = ~clk_i;

  function automatic bit class_allowed(input int note);
    int m;
    m = int'(spq_pkg::ClassCount);
    return model_mask[((note % m) + m) % m];
  endfunction

  function automatic result_t quantize_word(input logic [1:0] cmd, input logic [14:0] pitch,
                                            input logic [3:0] cls, input logic allow);
    result_t     r;
    int          nearest, pick, c, d;
    bit          below_first, found;
    logic [3:0]  kind;
    logic [23:0] twice;
    r.note  = '0;
    r.exact = 1'b0;
    case (cmd)
      spq_pkg::CMD_SNAP: begin
        nearest     = (int'(pitch) + 128) >> 8;
        below_first = int'(pitch) <= nearest * 256;
        pick        = nearest;
        found       = class_allowed(nearest);
        r.exact     = found;
        for (d = 1; d <= int'(spq_pkg::SearchMax) && !found; d++) begin
          if (below_first && class_allowed(nearest - d)) begin
            pick = nearest - d;
            found = 1'b1;
          end else if (class_allowed(nearest + d)) begin
            pick = nearest + d;
            found = 1'b1;
          end else if (class_allowed(nearest - d)) begin
            pick = nearest - d;
            found = 1'b1;
          end
        end
        r.note = 9'(pick);
      end
      spq_pkg::CMD_EDIT: begin
        c = int'(cls) % int'(spq_pkg::ClassCount);
        if (model_mask[c] != allow) begin
          model_mask[c] = allow;
          model_kind = spq_pkg::KindCustom;
          if (model_mask == '0) model_mask[c] = 1'b1;
        end
      end
      spq_pkg::CMD_REBUILD: begin
        kind = (reg_kind > spq_pkg::KindCustom) ? spq_pkg::KindChrom : reg_kind;
        twice = {ScaleTable[kind], ScaleTable[kind]} << (reg_tonic % 4'd12);
        model_mask = twice[23:12];
        model_kind = kind;
      end
      default: ;
    endcase
    r.mask = model_mask;
    r.kind = model_kind;
    return r;
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [14:0] pitch,
                           input logic [3:0] cls, input logic allow);
    bit taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if (!gapless && $urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, allow, cls, pitch};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = s_axis_tready;
      if (taken) begin
        due_results.push_back(quantize_word(cmd, pitch, cls, allow));
        words_sent++;
        word_count[cmd]++;
      end
      @(posedge clk_i);
    end
  endtask

  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_scale(input logic [3:0] kind, input logic [3:0] tonic);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= spq_pkg::IdxScaleKind;
    cfg_wdata_i <= kind;
    @(posedge clk_i);
    cfg_idx_i   <= spq_pkg::IdxTonic;
    cfg_wdata_i <= tonic;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reg_kind  = kind;
    reg_tonic = tonic;
    scale_writes++;
  endtask

  function automatic logic [14:0] pick_pitch(input bit low_only);
    int n;
    n = $urandom_range(0, 127);
    if (low_only) return 15'($urandom_range(0, 2047));
    case ($urandom_range(0, 6))
      0: return 15'(n * 256 + 128);
      1: return 15'(n * 256 + 127);
      2: return 15'(n * 256 + 129);
      3: return 15'($urandom_range(0, 1535));
      4: return ($urandom_range(0, 15) == 0) ? 15'h7FFF : 15'(n * 256);
      default: return 15'($urandom);
    endcase
  endfunction

  task automatic send_snaps(input int count, input bit low_only);
    repeat (count)
      send_word(spq_pkg::CMD_SNAP, pick_pitch(low_only), 4'($urandom), 1'($urandom));
  endtask

  task automatic test_snap_extremes();
    send_word(spq_pkg::CMD_SNAP, 15'd0, 4'd0, 1'b0);
    send_word(spq_pkg::CMD_SNAP, 15'd127, 4'd0, 1'b0);
    send_word(spq_pkg::CMD_SNAP, 15'd128, 4'd0, 1'b0);
    send_word(spq_pkg::CMD_SNAP, 15'h7FFF, 4'hF, 1'b1);
  endtask

  task automatic test_edit_cases();
    send_word(spq_pkg::CMD_EDIT, 15'd0, 4'd0, 1'b0);
    send_word(spq_pkg::CMD_EDIT, 15'd0, 4'd0, 1'b0);
    send_word(spq_pkg::CMD_EDIT, 15'h7FFF, 4'd15, 1'b1);
    send_word(spq_pkg::CMD_EDIT, 15'd0, 4'd13, 1'b0);
    send_word(spq_pkg::CMD_SNAP, 15'd0, 4'd0, 1'b0);
    send_word(spq_pkg::CMD_SNAP, 15'd383, 4'd0, 1'b0);
    send_word(CmdNoop, 15'h5555, 4'hA, 1'b1);
  endtask

  task automatic test_rebuild_cases();
    set_scale(4'd4, 4'd11);
    send_word(spq_pkg::CMD_REBUILD, 15'd0, 4'd0, 1'b0);
    send_word(spq_pkg::CMD_SNAP, 15'd0, 4'd0, 1'b0);
    send_word(spq_pkg::CMD_SNAP, 15'd1152, 4'd0, 1'b0);
    set_scale(4'd15, 4'd15);
    send_word(spq_pkg::CMD_REBUILD, 15'd0, 4'd0, 1'b0);
    set_scale(spq_pkg::KindCustom, 4'd0);
    send_word(spq_pkg::CMD_REBUILD, 15'd0, 4'd0, 1'b0);
  endtask

  task automatic test_last_class();
    set_scale(4'd4, 4'd0);
    send_word(spq_pkg::CMD_REBUILD, 15'd0, 4'd0, 1'b0);
    send_word(spq_pkg::CMD_EDIT, 15'd0, 4'd2, 1'b0);
    send_word(spq_pkg::CMD_EDIT, 15'd0, 4'd4, 1'b0);
    send_word(spq_pkg::CMD_EDIT, 15'd0, 4'd7, 1'b0);
    send_word(spq_pkg::CMD_EDIT, 15'd0, 4'd9, 1'b0);
    send_word(spq_pkg::CMD_EDIT, 15'd0, 4'd0, 1'b0);
    send_word(spq_pkg::CMD_EDIT, 15'd0, 4'd6, 1'b1);
    send_word(spq_pkg::CMD_EDIT, 15'd0, 4'd12, 1'b0);
    send_word(spq_pkg::CMD_SNAP, 15'd0, 4'd0, 1'b0);
  endtask

  task automatic test_backpressure();
    set_scale(4'd1, 4'd7);
    send_word(spq_pkg::CMD_REBUILD, 15'd0, 4'd0, 1'b0);
    hold_reqs <= hold_reqs + 1;
    gapless = 1'b1;
    send_snaps(30, 1'b0);
    gapless = 1'b0;
    settle_idle();
  endtask

  task automatic test_random_traffic(input int target);
    int stop_at;
    logic [3:0] kind, tonic;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      kind  = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
      tonic = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(12, 15))
                                          : 4'($urandom_range(0, 11));
      set_scale(kind, tonic);
      repeat ($urandom_range(8, 20)) begin
        case ($urandom_range(0, 9))
          0: send_word(2'($urandom), 15'($urandom), 4'($urandom), 1'($urandom));
          1, 2: begin
            send_word(spq_pkg::CMD_REBUILD, 15'($urandom), 4'($urandom), 1'($urandom));
            send_snaps($urandom_range(3, 12), 1'b0);
          end
          3, 4: begin
            repeat ($urandom_range(1, 4))
              send_word(spq_pkg::CMD_EDIT, 15'($urandom), 4'($urandom), 1'($urandom));
            send_snaps($urandom_range(3, 10), 1'b0);
          end
          5, 6: begin
            repeat ($urandom_range(6, 14))
              send_word(spq_pkg::CMD_EDIT, 15'($urandom), 4'($urandom), 1'b0);
            send_snaps($urandom_range(3, 10), 1'b1);
          end
          default: send_snaps($urandom_range(4, 16), 1'b0);
        endcase
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      holds_done    <= 0;
      ready_mode    <= 0;
      mode_left     <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      holds_done    <= holds_done + 1;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(10, 120);
      end else begin
        mode_left  <= mode_left - 1;
      end
      case (ready_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(negedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("output word with no input pending: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tdata[8:0] !== want.note) begin
          $error("snapped_note: expected %0d, got %0d", want.note,
                 $signed(m_axis_tdata[8:0]));
          fail_count++;
        end
        if (m_axis_tdata[9] !== want.exact) begin
          $error("was_exact: expected %0d, got %0d", want.exact, m_axis_tdata[9]);
          fail_count++;
        end
        if (m_axis_tdata[21:10] !== want.mask) begin
          $error("mask_now: expected %h, got %h", want.mask, m_axis_tdata[21:10]);
          fail_count++;
        end
        if (m_axis_tdata[25:22] !== want.kind) begin
          $error("kind_now: expected %0d, got %0d", want.kind, m_axis_tdata[25:22]);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(negedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_snap_extremes();
    test_edit_cases();
    test_rebuild_cases();
    test_last_class();
    test_backpressure();
    test_random_traffic(RandomWords);
    settle_idle();
    repeat (4) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d expected output words never arrived", due_results.size());
      fail_count++;
    end
    $display("Checked %0d output words for %0d input words: %0d snap, %0d edit, %0d rebuild,",
             results_seen, words_sent, word_count[spq_pkg::CMD_SNAP],
             word_count[spq_pkg::CMD_EDIT], word_count[spq_pkg::CMD_REBUILD]);
    $display("%0d no-op; %0d scale/tonic settings, random stalls and a long output hold-off.",
             word_count[CmdNoop], scale_writes);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
